// ===== design/mpe_pkg.sv =====
// shared constants and types for the mandelbrot escape-time block
package mpe_pkg;
	localparam int FRAC_BITS = 28;
	localparam int IMAGE_WIDTH = 1024;
	localparam int IMAGE_HEIGHT = 1024;
	localparam int COL_W = 10;
	localparam int ROW_W = 10;
	localparam int IDX_W = 20;
	localparam int CNT_W = 8;
	localparam int NUM_CELLS = 4;
	localparam logic [CNT_W-1:0] RED_MAX = 8'd255;

	localparam logic [2:0] REG_X_START = 3'd0;
	localparam logic [2:0] REG_X_STEP = 3'd1;
	localparam logic [2:0] REG_Y_START = 3'd2;
	localparam logic [2:0] REG_Y_STEP = 3'd3;
	localparam logic [2:0] REG_ITER_LIMIT = 3'd4;

	// one token travelling along the cell row
	typedef struct packed {
		logic                    live;
		logic                    done;
		logic [CNT_W-1:0]        n;
		logic signed [31:0]      zr;
		logic signed [31:0]      zi;
		logic signed [31:0]      cr;
		logic signed [31:0]      ci;
	} tok_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) r = 32'sh7fffffff;
		else if (v < -64'sd2147483648) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction
endpackage

// ===== design/mpe_if.sv =====
// valid/ready channel interface
interface mpe_if #(parameter int W = 1);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== design/mandelbrot_pixel_escape_top.sv =====
// Mandelbrot escape-time evaluator: top level with mapping, cell ring and output
// flow: mapping states MAP1 and MAP2, then passes round a ring of 4 cells (4 iterations
// a pass) until done, then the output state OUT
// throughput: one pixel at a time, next beat taken in the cycle after the output beat
// reset: arst_n clears control and loads the default view registers
module mandelbrot_pixel_escape_top
	import mpe_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_data,
	mpe_if.sink   pix_in,
	mpe_if.source pix_out
);
	typedef enum logic [2:0] {IDLE, MAP1, MAP2, RUN, OUT} state_t;
	state_t state_q;

	logic signed [31:0] x_start_q, x_step_q, y_start_q, y_step_q;
	logic [CNT_W-1:0] limit_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic signed [63:0] xp_q, yp_q;
	logic [CNT_W-1:0] cnt_q, red_q;
	logic [IDX_W-1:0] idx_q;
	logic [4:0] pass_q;
	tok_t inj, feed;
	tok_t link [NUM_CELLS+1];
	logic [9:0] red3;

	assign pix_in.ready = (state_q == IDLE);
	assign pix_out.valid = (state_q == OUT);
	assign pix_out.data = {idx_q, cnt_q, red_q};
	assign red3 = 10'(link[NUM_CELLS].n) * 10'd3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_start_q <= -32'sd536870912;
			x_step_q <= 32'sd786432;
			y_start_q <= 32'sd402653184;
			y_step_q <= -32'sd786432;
			limit_q <= 8'd85;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_X_START: x_start_q <= cfg_data;
				REG_X_STEP: x_step_q <= cfg_data;
				REG_Y_START: y_start_q <= cfg_data;
				REG_Y_STEP: y_step_q <= cfg_data;
				REG_ITER_LIMIT: limit_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		inj = '0;
		inj.live = (state_q == MAP2);
		inj.zr = sat32(64'(x_start_q) + xp_q);
		inj.zi = sat32(64'(y_start_q) + yp_q);
		inj.cr = inj.zr;
		inj.ci = inj.zi;
		feed = inj.live ? inj : link[NUM_CELLS];
		link[0] = feed;
	end

	for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
		mpe_cell u_cell (.clk(clk), .arst_n(arst_n), .limit(limit_q),
			.tin(link[g]), .tout(link[g+1]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			pass_q <= '0;
			cnt_q <= '0;
			red_q <= '0;
		end else begin
			unique case (state_q)
				IDLE: if (pix_in.valid) state_q <= MAP1;
				MAP1: state_q <= MAP2;
				MAP2: begin
					state_q <= RUN;
					pass_q <= 5'd0;
				end
				RUN: begin
					// token returns to the ring entry once per pass through all cells
					if (pass_q == 5'(3 * NUM_CELLS - 1)) begin
						pass_q <= 5'd0;
						if (link[NUM_CELLS].done) begin
							state_q <= OUT;
							cnt_q <= link[NUM_CELLS].n;
							red_q <= (red3 > 10'(RED_MAX)) ? RED_MAX : red3[7:0];
						end
					end else begin
						pass_q <= pass_q + 5'd1;
					end
				end
				OUT: if (pix_out.ready) state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == IDLE) begin
			col_q <= pix_in.data[COL_W+ROW_W-1:ROW_W];
			row_q <= pix_in.data[ROW_W-1:0];
		end
		if (state_q == MAP1) begin
			xp_q <= 64'(x_step_q) * $signed({1'b0, col_q});
			yp_q <= 64'(y_step_q) * $signed({1'b0, row_q});
			idx_q <= IDX_W'({row_q, col_q});
		end
	end

`ifndef SYNTH
	a_one_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == OUT) |-> !link[NUM_CELLS].live || link[NUM_CELLS].done)
		else $error("token still running at output");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_out.valid && !pix_out.ready) |=> $stable(pix_out.data))
		else $error("result changed while stalled");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == RUN) |-> !pix_in.ready)
		else $error("accepted while busy");
`endif
endmodule

// ===== design/mpe_cell.sv =====
// one iteration cell: escape test and z = z^2 + c over three stages
module mpe_cell
	import mpe_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic [CNT_W-1:0] limit,
	input  tok_t tin,
	output tok_t tout
);
	tok_t tok_s1, tok_s2;
	logic signed [63:0] rr_s1, ii_s1, ri_s1;
	logic signed [63:0] re_s2, im_s2;
	logic esc_s2;
	logic signed [64:0] mag;
	logic signed [63:0] nr, ni;

	always_comb begin
		mag = 65'(rr_s1) + 65'(ii_s1);
		nr = (re_s2 >>> FRAC_BITS) + 64'(tok_s2.cr);
		ni = (im_s2 >>> (FRAC_BITS - 1)) + 64'(tok_s2.ci);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
			tok_s2 <= '0;
			tout <= '0;
			rr_s1 <= '0;
			ii_s1 <= '0;
			ri_s1 <= '0;
			re_s2 <= '0;
			im_s2 <= '0;
			esc_s2 <= 1'b0;
		end else begin
			tok_s1 <= tin;
			rr_s1 <= 64'(tin.zr) * 64'(tin.zr);
			ii_s1 <= 64'(tin.zi) * 64'(tin.zi);
			ri_s1 <= 64'(tin.zr) * 64'(tin.zi);
			tok_s2 <= tok_s1;
			re_s2 <= rr_s1 - ii_s1;
			im_s2 <= ri_s1;
			esc_s2 <= (mag >= (65'sd1 <<< (2 * FRAC_BITS + 2)));
			tout.live <= tok_s2.live;
			tout.cr <= tok_s2.cr;
			tout.ci <= tok_s2.ci;
			if (tok_s2.done) begin
				tout.done <= 1'b1;
				tout.n <= tok_s2.n;
				tout.zr <= tok_s2.zr;
				tout.zi <= tok_s2.zi;
			end else if (esc_s2) begin
				tout.done <= 1'b1;
				tout.n <= tok_s2.n;
				tout.zr <= tok_s2.zr;
				tout.zi <= tok_s2.zi;
			end else if (tok_s2.n == limit) begin
				// never escaped within the limit
				tout.done <= 1'b1;
				tout.n <= '0;
				tout.zr <= tok_s2.zr;
				tout.zi <= tok_s2.zi;
			end else begin
				tout.done <= 1'b0;
				tout.n <= tok_s2.n + 1'b1;
				tout.zr <= sat32(nr);
				tout.zi <= sat32(ni);
			end
		end
	end
endmodule

// ===== verif/tb_top.sv =====
// testbench for the mandelbrot escape-time pixel block
`timescale 1ns / 1ps
module tb_top;
	import mpe_pkg::*;

	localparam int IN_W = COL_W + ROW_W;
	localparam int OUT_W = IDX_W + 2 * CNT_W;
	localparam int STALL_LIMIT = 6000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	mpe_if #(.W(IN_W)) pix_in ();
	mpe_if #(.W(OUT_W)) pix_out ();

	mandelbrot_pixel_escape_top dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .pix_in(pix_in.sink), .pix_out(pix_out.source)
	);

	typedef struct {
		logic [IDX_W-1:0] pixel_index;
		logic [CNT_W-1:0] escape_count;
		logic [CNT_W-1:0] red_level;
	} pixel_result_t;

	// view registers as the block should hold them
	logic signed [31:0] view_x0, view_dx, view_y0, view_dy;
	logic [7:0] view_limit;

	pixel_result_t pending_pixels[$];
	int errors = 0;
	bit src_idle_en = 1'b1;
	bit snk_idle_en = 1'b1;
	int hold_req = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	always #1 clk = ~clk;

	initial begin
		pix_in.valid = 1'b0;
		pix_in.data = '0;
		pix_out.ready = 1'b0;
	end

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > longint'(32'sh7fffffff)) return 32'sh7fffffff;
		if (v < -longint'(64'sd2147483648)) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic [CNT_W-1:0] escape_iters(logic signed [31:0] cr,
			logic signed [31:0] ci);
		longint zr, zi, re, im;
		longint unsigned mag;
		int n;
		zr = cr;
		zi = ci;
		for (n = 0; n <= view_limit; n++) begin
			mag = longint'(zr * zr) + longint'(zi * zi);
			if (mag >= (64'd1 << 58)) return n[CNT_W-1:0];
			re = zr * zr - zi * zi;
			im = zr * zi;
			zr = clamp32((re >>> FRAC_BITS) + longint'(cr));
			zi = clamp32((im >>> (FRAC_BITS - 1)) + longint'(ci));
		end
		return '0;
	endfunction

	function automatic pixel_result_t eval_pixel(logic [COL_W-1:0] col,
			logic [ROW_W-1:0] row);
		pixel_result_t r;
		logic signed [31:0] cr, ci;
		int red;
		cr = clamp32(longint'(view_x0) + longint'(col) * longint'(view_dx));
		ci = clamp32(longint'(view_y0) + longint'(row) * longint'(view_dy));
		r.escape_count = escape_iters(cr, ci);
		red = 3 * r.escape_count;
		r.red_level = (red > RED_MAX) ? RED_MAX : red[CNT_W-1:0];
		r.pixel_index = IDX_W'(row * IMAGE_WIDTH + col);
		return r;
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_X_START: view_x0 = val;
			REG_X_STEP: view_dx = val;
			REG_Y_START: view_y0 = val;
			REG_Y_STEP: view_dy = val;
			REG_ITER_LIMIT: view_limit = val[7:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_view(logic [31:0] x0, logic [31:0] dx, logic [31:0] y0,
			logic [31:0] dy, logic [7:0] lim);
		write_reg(REG_X_START, x0);
		write_reg(REG_X_STEP, dx);
		write_reg(REG_Y_START, y0);
		write_reg(REG_Y_STEP, dy);
		write_reg(REG_ITER_LIMIT, {24'd0, lim});
	endtask

	task automatic send_pixel(logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
		if (src_idle_en && $urandom_range(0, 3) == 0) begin
			pix_in.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		pix_in.valid <= 1'b1;
		pix_in.data <= {col, row};
		do @(posedge clk); while (!pix_in.ready);
		pending_pixels.push_back(eval_pixel(col, row));
	endtask

	task automatic drain;
		@(posedge clk);
		pix_in.valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_random(int count, bit full_range);
		repeat (count) begin
			if (full_range)
				send_pixel(COL_W'($urandom), ROW_W'($urandom));
			else
				send_pixel(COL_W'($urandom_range(0, 1023)), ROW_W'($urandom_range(0, 1023)));
		end
	endtask

	task automatic test_default_view;
		send_pixel(0, 0);
		send_pixel(1023, 1023);
		send_pixel(1023, 0);
		send_pixel(0, 1023);
		send_pixel(683, 512);
		send_pixel(512, 512);
		send_pixel(10'h2aa, 10'h155);
		send_pixel(10'h155, 10'h2aa);
		drain();
	endtask

	task automatic test_extremes;
		// mapping saturates at both ends
		set_view(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 8'd255);
		send_pixel(0, 0);
		send_pixel(1023, 1023);
		drain();
		// origin never escapes: full-length run at the top limit
		set_view(32'h0, 32'h0, 32'h0, 32'h0, 8'd255);
		send_pixel(5, 7);
		drain();
		// limit of zero tests only the first iteration
		set_view(32'h20000000, 32'h0, 32'h0, 32'h0, 8'd0);
		send_pixel(0, 0);
		drain();
		write_reg(REG_X_START, 32'h0);
		send_pixel(3, 3);
		drain();
		// exactly on the circle, and a point escaping late
		set_view(32'he0000000, 32'h0, 32'h0, 32'h0, 8'd1);
		send_pixel(1, 1);
		drain();
		set_view(32'h04000000, 32'h00010000, 32'h0, 32'h00008000, 8'd200);
		send_pixel(0, 0);
		send_pixel(1023, 1023);
		drain();
		write_reg(3'd7, 32'hdeadbeef);
		write_reg(3'd5, 32'h12345678);
		set_view(32'he0000000, 32'h000c0000, 32'h18000000, 32'hfff40000, 8'd85);
		send_pixel(600, 400);
		drain();
	endtask

	task automatic test_random_views;
		logic [31:0] x0, y0, dx, dy;
		repeat (12) begin
			x0 = $urandom_range(0, 3) == 0 ? $urandom : 32'hd8000000 + $urandom_range(0, 32'h38000000);
			y0 = $urandom_range(0, 3) == 0 ? $urandom : 32'he8000000 + $urandom_range(0, 32'h30000000);
			dx = $urandom_range(0, 5) == 0 ? $urandom : $signed($urandom_range(0, 32'h00200000)) - 32'sh00100000;
			dy = $urandom_range(0, 5) == 0 ? $urandom : $signed($urandom_range(0, 32'h00200000)) - 32'sh00100000;
			set_view(x0, dx, y0, dy,
				$urandom_range(0, 7) == 0 ? 8'd255 : 8'($urandom_range(1, 60)));
			send_random(80, 1'($urandom_range(0, 1)));
			drain();
		end
	endtask

	task automatic test_backpressure;
		set_view(32'he0000000, 32'h000c0000, 32'h18000000, 32'hfff40000, 8'd20);
		hold_req = 300;
		send_random(60, 1'b0);
		drain();
	endtask

	task automatic test_streaming;
		src_idle_en = 1'b0;
		snk_idle_en = 1'b0;
		set_view(32'he0000000, 32'h000c0000, 32'h18000000, 32'hfff40000, 8'd85);
		send_random(250, 1'b0);
		drain();
	endtask

	// sink side ready, with random idling and a long hold-off on request
	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			pix_out.ready <= 1'b0;
		end else if (snk_idle_en && $urandom_range(0, 4) == 0) begin
			pix_out.ready <= 1'b0;
			hold_left = $urandom_range(0, 2);
		end else begin
			pix_out.ready <= 1'b1;
		end
	end

	// compare each output beat with the oldest predicted pixel
	always @(posedge clk) begin
		pixel_result_t want;
		logic [IDX_W-1:0] got_idx;
		logic [CNT_W-1:0] got_cnt, got_red;
		if (arst_n && pix_out.valid && pix_out.ready) begin
			{got_idx, got_cnt, got_red} = pix_out.data;
			if (pending_pixels.size() == 0) begin
				$error("unexpected output beat: pixel_index %0d", got_idx);
				errors++;
			end else begin
				want = pending_pixels.pop_front();
				if (got_idx !== want.pixel_index) begin
					$error("pixel_index: expected %0d, actual %0d", want.pixel_index, got_idx);
					errors++;
				end
				if (got_cnt !== want.escape_count) begin
					$error("escape_count: expected %0d, actual %0d", want.escape_count, got_cnt);
					errors++;
				end
				if (got_red !== want.red_level) begin
					$error("red_level: expected %0d, actual %0d", want.red_level, got_red);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready))
			quiet_cycles = 0;
		else if (pix_in.valid || pending_pixels.size() != 0)
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("mandelbrot_pixel_escape_top regression: fail");
			$finish;
		end
	end

	initial begin
		view_x0 = -32'sd536870912;
		view_dx = 32'sd786432;
		view_y0 = 32'sd402653184;
		view_dy = -32'sd786432;
		view_limit = 8'd85;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_default_view();
		test_extremes();
		test_random_views();
		test_backpressure();
		test_streaming();
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("mandelbrot_pixel_escape_top regression: pass");
		else
			$display("mandelbrot_pixel_escape_top regression: fail");
		$finish;
	end
endmodule
